>>> src/csv_structural_indexer_core_defines.svh
// Assertion macros shared by the structural indexer.
`ifndef CSV_STRUCTURAL_INDEXER_CORE_DEFINES_SVH
`define CSV_STRUCTURAL_INDEXER_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define CSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define CSI_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> src/csi_pkg.sv
`default_nettype none

package csi_pkg;

   localparam int unsigned DEFAULT_BYTES_PER_CHUNK = 8;
   localparam int unsigned DEFAULT_POSITION_WIDTH  = 32;

   localparam int unsigned CHUNK_WIDTH    = 64;
   localparam int unsigned COUNT_WIDTH    = 4;
   localparam int unsigned OUT_WIDTH      = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SEPARATOR    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUOTE_ENABLE = 2'd1;

   localparam logic [7:0] QUOTE_BYTE         = 8'd34;
   localparam logic [7:0] NEWLINE_BYTE       = 8'd10;
   localparam logic [7:0] SEPARATOR_RESET    = 8'd44;
   localparam logic       QUOTE_ENABLE_RESET = 1'b1;

   typedef struct packed {
      logic [CHUNK_WIDTH-1:0] chunk_bytes;
      logic [COUNT_WIDTH-1:0] valid_bytes;
   } csi_req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] position;
      logic [OUT_WIDTH-1:0] ordinal;
      logic                 last_of_run;
   } csi_rsp_type;

   typedef struct packed {
      logic accept;
      logic emit;
   } csi_cmd_type;

   typedef struct packed {
      logic chunk_has_hits;
      logic pending_last;
      logic out_free;
   } csi_status_type;

endpackage

`default_nettype wire

>>> src/csi_ctrl.sv
`default_nettype none

module csi_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire csi_pkg::csi_status_type status,
   output csi_pkg::csi_cmd_type         cmd
);
   import csi_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.emit   = (state_ff == ST_EMIT) && status.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.chunk_has_hits) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit && status.pending_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> src/csi_datapath.sv
`default_nettype none

module csi_datapath #(
   parameter int unsigned BYTES_PER_CHUNK = csi_pkg::DEFAULT_BYTES_PER_CHUNK,
   parameter int unsigned POSITION_WIDTH  = csi_pkg::DEFAULT_POSITION_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire csi_pkg::csi_cmd_type                cmd,
   output csi_pkg::csi_status_type                  status,
   input  wire csi_pkg::csi_req_type                req_payload,
   input  wire logic                                csr_write,
   input  wire logic [csi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [csi_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output csi_pkg::csi_rsp_type                     rsp_payload
);
   import csi_pkg::*;

   localparam int unsigned IDX_WIDTH =
      (BYTES_PER_CHUNK > 1) ? $clog2(BYTES_PER_CHUNK) : 1;
   localparam logic [COUNT_WIDTH-1:0] CHUNK_LIMIT = COUNT_WIDTH'(BYTES_PER_CHUNK);

   logic [7:0]                 sep_ff, sep_in;
   logic                       qen_ff, qen_in;
   logic                       quote_ff, quote_in;
   logic [POSITION_WIDTH-1:0]  offset_ff, offset_in;
   logic [POSITION_WIDTH-1:0]  base_ff, base_in;
   logic [OUT_WIDTH-1:0]       found_ff, found_in;
   logic [BYTES_PER_CHUNK-1:0] pend_ff, pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   csi_rsp_type                rsp_data_ff, rsp_data_in;

   logic [COUNT_WIDTH-1:0]     count;
   logic [BYTES_PER_CHUNK-1:0] hits;
   logic                       scan_quote;
   logic                       quoted;
   logic [7:0]                 cur;
   logic                       live;
   logic [BYTES_PER_CHUNK-1:0] low_bit;
   logic [BYTES_PER_CHUNK-1:0] rest;
   logic [IDX_WIDTH-1:0]       idx;
   logic [POSITION_WIDTH-1:0]  hit_pos;

   // Walk the chunk once, carrying the quote state from byte to byte.
   always_comb begin
      count  = (req_payload.valid_bytes > CHUNK_LIMIT) ? CHUNK_LIMIT
                                                       : req_payload.valid_bytes;
      quoted = quote_ff;
      cur    = '0;
      live   = 1'b0;
      hits   = '0;
      for (int k = 0; k < BYTES_PER_CHUNK; k++) begin
         cur  = req_payload.chunk_bytes[8*k +: 8];
         live = (COUNT_WIDTH'(k) < count);
         if (live && qen_ff && (cur == QUOTE_BYTE)) begin
            quoted = !quoted;
         end
         hits[k] = live && !(qen_ff && quoted) &&
                   ((cur == sep_ff) || (cur == NEWLINE_BYTE));
      end
      scan_quote = quoted;
   end

   // Lowest pending hit goes out first.
   always_comb begin
      low_bit = pend_ff & (~pend_ff + BYTES_PER_CHUNK'(1));
      rest    = pend_ff & ~low_bit;
      idx     = '0;
      for (int k = 0; k < BYTES_PER_CHUNK; k++) begin
         if (low_bit[k]) begin
            idx = IDX_WIDTH'(k);
         end
      end
   end

   // The position wraps at the position width before it is widened or cut.
   assign hit_pos = base_ff + POSITION_WIDTH'(idx);

   assign status.chunk_has_hits = |hits;
   assign status.pending_last   = (rest == '0);
   assign status.out_free       = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sep_in = sep_ff;
      qen_in = qen_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SEPARATOR:    sep_in = csr_data;
            REG_QUOTE_ENABLE: qen_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      quote_in     = (cmd.accept && qen_ff) ? scan_quote : quote_ff;
      offset_in    = cmd.accept ? offset_ff + POSITION_WIDTH'(count) : offset_ff;
      base_in      = cmd.accept ? offset_ff : base_ff;
      pend_in      = cmd.accept ? hits : (cmd.emit ? rest : pend_ff);
      found_in     = cmd.emit ? found_ff + OUT_WIDTH'(1) : found_ff;
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_data_in.position    = OUT_WIDTH'(hit_pos);
         rsp_data_in.ordinal     = found_ff;
         rsp_data_in.last_of_run = status.pending_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff       <= SEPARATOR_RESET;
         qen_ff       <= QUOTE_ENABLE_RESET;
         quote_ff     <= 1'b0;
         offset_ff    <= '0;
         found_ff     <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sep_ff       <= sep_in;
         qen_ff       <= qen_in;
         quote_ff     <= quote_in;
         offset_ff    <= offset_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/csv_structural_indexer_core.sv
// CSV structural indexer. Text arrives as chunks of up to BYTES_PER_CHUNK bytes,
// byte zero in the low bits, and every separator or newline byte that lies
// outside double quotes (anywhere, if quoting is off) comes out as a result
// beat carrying its absolute byte position and its running ordinal, lowest
// position first, with last_of_run set on the final beat of the chunk. A chunk
// with no such byte produces no beat. The in-quote flag carries across chunks,
// so a doubled quote cancels itself. Timing: a chunk is taken, then its
// results leave through a single output register at one per cycle as long as
// the result side does not stall. A chunk with no structural bytes leaves the
// controller idle; any other chunk keeps the input stalled until its last
// result is loaded. A stalled beat that keeps the output register full delays
// the next load, and so the chunk. The next chunk is taken as soon as the last
// result of the current one has been loaded into the output register, even
// while that result still waits downstream. Configuration writes are always
// ready and are meant to happen only while the block is idle.

`default_nettype none

`include "csv_structural_indexer_core_defines.svh"

module csv_structural_indexer_core #(
   parameter int unsigned BYTES_PER_CHUNK = csi_pkg::DEFAULT_BYTES_PER_CHUNK,
   parameter int unsigned POSITION_WIDTH  = csi_pkg::DEFAULT_POSITION_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire csi_pkg::csi_req_type                req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output csi_pkg::csi_rsp_type                     rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [csi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [csi_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import csi_pkg::*;

   csi_cmd_type    cmd;
   csi_status_type status;
   logic           csr_write;

   // Register writes never wait.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // The controller decides when a chunk is taken and when a result beat is
   // loaded into the output register.
   csi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath scans the chunk, keeps the quote flag, offset and count, and
   // holds the pending hit mask and the output register.
   csi_datapath #(
      .BYTES_PER_CHUNK (BYTES_PER_CHUNK),
      .POSITION_WIDTH  (POSITION_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A chunk is never taken in the same cycle as a result is loaded.
   `CSI_ASSERT(a_accept_emit_excl, clock, reset, !(cmd.accept && cmd.emit),
      "accept during emit")
   // A chunk with structural bytes blocks the input until its results are out.
   `CSI_ASSERT_NEXT(a_hits_stall, clock, reset,
      cmd.accept && status.chunk_has_hits, req_stall, "no stall after hit chunk")
   // Loading the last result of a chunk frees the input in the next cycle.
   `CSI_ASSERT_NEXT(a_last_frees, clock, reset, cmd.emit && status.pending_last,
      !req_stall, "input still stalled after last beat")
   // Every loaded result shows up as a valid beat.
   `CSI_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid, "loaded beat not valid")

endmodule

`default_nettype wire
